@@ rtl/core/i2c_master_byte_writer_assert.svh @@
// ----------------------------------------------------------------------------
// I2C byte writer assertion macros
// Shorthand for the concurrent checks of the byte writer, clocked on clk
// and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_WRITER_ASSERT_SVH
`define I2C_MASTER_BYTE_WRITER_ASSERT_SVH

// Same-cycle implication
`define I2CW_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication
`define I2CW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ rtl/core/i2cw_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C byte writer package
// Phase codes, word types and fixed constants shared by the byte writer.
// ----------------------------------------------------------------------------
package i2cw_pkg;

    localparam int unsigned TICK_W    = 16;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned BIT_POS_W = 3;

    localparam logic [BIT_POS_W-1:0] MSB_INDEX         = 3'd7;
    localparam logic [TICK_W-1:0]    PHASE_TICKS_RESET = 16'd200;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START_A  = 4'd1,
        PH_START_B  = 4'd2,
        PH_BIT_LOW  = 4'd3,
        PH_BIT_HIGH = 4'd4,
        PH_ACK_LOW  = 4'd5,
        PH_ACK_HIGH = 4'd6,
        PH_ACK_HOLD = 4'd7,
        PH_HOLD     = 4'd8,
        PH_STOP_A   = 4'd9,
        PH_STOP_B   = 4'd10
    } bus_phase_t;

    typedef struct packed {
        logic              operation;
        logic [BYTE_W-1:0] tx_byte;
        logic              end_of_message;
        logic              sda_sample;
    } item_t;

    typedef struct packed {
        logic scl_pull_low;
        logic sda_pull_low;
        logic ready_res;
        logic ack_valid;
        logic nack;
        logic finished;
    } result_t;

endpackage

@@ rtl/core/i2cw_seq.sv @@
// ----------------------------------------------------------------------------
// I2C byte writer sequencer
// Holds the bus phase, bit pointer, shift register and phase timer, and
// advances them by one tick per enabled cycle.
// ----------------------------------------------------------------------------
module i2cw_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step_en,
    input  i2cw_pkg::item_t              item,
    input  logic [i2cw_pkg::TICK_W-1:0]  phase_ticks,
    output i2cw_pkg::result_t            result
);
    import i2cw_pkg::*;

    bus_phase_t           phase_reg, phase_next;
    logic [BIT_POS_W-1:0] bit_pos_reg, bit_pos_next;
    logic [BYTE_W-1:0]    shift_reg, shift_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic                 last_reg, last_next;
    logic                 open_reg, open_next;

    logic [TICK_W-1:0]    limit;
    logic [TICK_W-1:0]    tick_inc;
    logic                 ready_now;
    logic                 cur_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            bit_pos_reg <= '0;
            shift_reg   <= '0;
            tick_reg    <= '0;
            last_reg    <= 1'b0;
            open_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            bit_pos_reg <= bit_pos_next;
            shift_reg   <= shift_next;
            tick_reg    <= tick_next;
            last_reg    <= last_next;
            open_reg    <= open_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        bit_pos_next = bit_pos_reg;
        shift_next   = shift_reg;
        tick_next    = tick_reg;
        last_next    = last_reg;
        open_next    = open_reg;
        result       = '0;

        // zero length behaves as one tick
        limit     = (phase_ticks == '0) ? {{(TICK_W-1){1'b0}}, 1'b1} : phase_ticks;
        tick_inc  = tick_reg + {{(TICK_W-1){1'b0}}, 1'b1};
        ready_now = (phase_reg inside {PH_IDLE, PH_HOLD});

        if (item.operation && ready_now)
        begin
            shift_next   = item.tx_byte;
            last_next    = item.end_of_message;
            bit_pos_next = MSB_INDEX;
            tick_next    = '0;
            phase_next   = open_reg ? PH_BIT_LOW : PH_START_A;
            open_next    = 1'b1;
        end
        else if (!ready_now)
        begin
            tick_next = tick_inc;
            if (tick_inc >= limit)
            begin
                tick_next = '0;
                case (phase_reg)
                    PH_START_A: phase_next = PH_START_B;
                    PH_START_B:
                    begin
                        bit_pos_next = MSB_INDEX;
                        phase_next   = PH_BIT_LOW;
                    end
                    PH_BIT_LOW: phase_next = PH_BIT_HIGH;
                    PH_BIT_HIGH:
                    begin
                        if (bit_pos_reg == '0)
                        begin
                            phase_next = PH_ACK_LOW;
                        end
                        else
                        begin
                            bit_pos_next = bit_pos_reg - {{(BIT_POS_W-1){1'b0}}, 1'b1};
                            phase_next   = PH_BIT_LOW;
                        end
                    end
                    PH_ACK_LOW: phase_next = PH_ACK_HIGH;
                    PH_ACK_HIGH:
                    begin
                        result.ack_valid = 1'b1;
                        result.nack      = item.sda_sample;
                        phase_next       = PH_ACK_HOLD;
                    end
                    PH_ACK_HOLD: phase_next = last_reg ? PH_STOP_A : PH_HOLD;
                    PH_STOP_A:   phase_next = PH_STOP_B;
                    PH_STOP_B:
                    begin
                        phase_next      = PH_IDLE;
                        open_next       = 1'b0;
                        last_next       = 1'b0;
                        result.finished = 1'b1;
                    end
                    default:
                    begin
                        // drop back to idle from a stray code
                        phase_next = PH_IDLE;
                        open_next  = 1'b0;
                    end
                endcase
            end
        end

        // drive levels follow the updated phase
        cur_bit = shift_next[bit_pos_next];
        case (phase_next)
            PH_START_B:  result.sda_pull_low = 1'b1;
            PH_BIT_LOW:
            begin
                result.scl_pull_low = 1'b1;
                result.sda_pull_low = ~cur_bit;
            end
            PH_BIT_HIGH: result.sda_pull_low = ~cur_bit;
            PH_ACK_LOW:  result.scl_pull_low = 1'b1;
            PH_HOLD:     result.scl_pull_low = 1'b1;
            PH_STOP_A:
            begin
                result.scl_pull_low = 1'b1;
                result.sda_pull_low = 1'b1;
            end
            PH_STOP_B:   result.sda_pull_low = 1'b1;
            default:     result.sda_pull_low = 1'b0;
        endcase
        result.ready_res = (phase_next inside {PH_IDLE, PH_HOLD});
    end

endmodule

@@ rtl/core/i2c_master_byte_writer.sv @@
// ----------------------------------------------------------------------------
// I2C master byte writer
// Open-drain I2C write sequencer, one bus tick per input word.
// ----------------------------------------------------------------------------
// Each input word is one tick of the bus timer and yields exactly one output
// word carrying the SCL/SDA pull-down levels and the status flags for that
// tick. One word is accepted every clock cycle; after acceptance a word is
// held in the input register, and its result passes through the sequencer
// into the output register. Throughput drops only when the output side
// stalls. phase_ticks sets how many ticks each bus phase lasts and should be
// written only while no words are in flight.
`include "i2c_master_byte_writer_assert.svh"

module i2c_master_byte_writer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [i2cw_pkg::TICK_W-1:0]       cfg_write_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              operation,
    input  logic [i2cw_pkg::BYTE_W-1:0]       tx_byte,
    input  logic                              end_of_message,
    input  logic                              sda_sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              scl_pull_low,
    output logic                              sda_pull_low,
    output logic                              ready_res,
    output logic                              ack_valid,
    output logic                              nack,
    output logic                              finished
);
    import i2cw_pkg::*;

    logic [TICK_W-1:0] phase_ticks_reg;
    logic              in_valid_reg;
    item_t             item_reg;
    logic              out_valid_reg;
    result_t           result_reg;
    result_t           step_result;
    logic              advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
        end
        else if (cfg_write_en)
        begin
            phase_ticks_reg <= cfg_write_data;
        end
    end

    // advance the held word when the output slot is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{operation:      operation,
                          tx_byte:        tx_byte,
                          end_of_message: end_of_message,
                          sda_sample:     sda_sample};
        end
    end

    i2cw_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .item        (item_reg),
        .phase_ticks (phase_ticks_reg),
        .result      (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign scl_pull_low = result_reg.scl_pull_low;
    assign sda_pull_low = result_reg.sda_pull_low;
    assign ready_res    = result_reg.ready_res;
    assign ack_valid    = result_reg.ack_valid;
    assign nack         = result_reg.nack;
    assign finished     = result_reg.finished;

    `I2CW_ASSERT_SAME(a_finish_releases_bus, out_valid && finished, !scl_pull_low && !sda_pull_low && ready_res)
    `I2CW_ASSERT_SAME(a_ack_releases_bus, out_valid && ack_valid, !scl_pull_low && !sda_pull_low && !finished)
    `I2CW_ASSERT_SAME(a_nack_needs_ack, out_valid && nack, ack_valid)
    `I2CW_ASSERT_NEXT(a_advance_fills_output, advance, out_valid)

endmodule
